>>> rtl/core/chp_pkg.sv
`timescale 1ns / 1ps
package chp_pkg;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned TDATA_W         = 3 * FIELD_W;
  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF  = 16;
endpackage

>>> rtl/core/chp_ram.sv
`timescale 1ns / 1ps
module chp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/core/chp_cross.sv
`timescale 1ns / 1ps
module chp_cross #(
  parameter int unsigned CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  output logic                 done_o,
  output logic                 not_left_o
);
  logic [1:0] vld_q;
  logic signed [CW:0] dbx_q, dby_q, dqx_q, dqy_q;
  logic signed [2*CW+1:0] m1_q, m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[0], start_i};
      done_o <= vld_q[1];
    end
  end

  // differences, then products, then compare
  always_ff @(posedge clk_i) begin
    dbx_q      <= (CW+1)'(bx_i) - (CW+1)'(ax_i);
    dby_q      <= (CW+1)'(by_i) - (CW+1)'(ay_i);
    dqx_q      <= (CW+1)'(px_i) - (CW+1)'(ax_i);
    dqy_q      <= (CW+1)'(py_i) - (CW+1)'(ay_i);
    m1_q       <= (2*CW+2)'(dbx_q) * (2*CW+2)'(dqy_q);
    m2_q       <= (2*CW+2)'(dby_q) * (2*CW+2)'(dqx_q);
    not_left_o <= m1_q <= m2_q;
  end
endmodule

>>> rtl/core/convex_hull_2d_top.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | tvalid/tready          | tdata {id, y, x}, tlast = final point
// m_axis   | out | tvalid/tready          | tdata {id, y, x}, tlast = last hull vertex
//
// Loading accepts one point per cycle. The run then sorts the points by insertion, each
// shift costing an order-memory read and a point-memory read, and walks the chain,
// each test of the top vertices costing two stack reads, two point-memory reads and a
// pass through the three-stage cross-product unit; the hull vertices then go out one
// at a time, the next fetched only after the last is taken.
// Reset clears only control state; the memories hold whatever was last written.
// A stalled vertex holds on m_axis; s_tready stays low from the final point
// until the last vertex is taken.
module convex_hull_2d_top
  import chp_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // point_x, point_y, point_id
  input  logic               s_axis_tlast_i,  // final_point
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,  // hull_x, hull_y, hull_id
  output logic               m_axis_tlast_o   // hull_end
);
  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned XW   = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int unsigned PW   = 2 * CW + FIELD_W;
  localparam int unsigned IW   = $clog2(MAX_POINTS);
  localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SD   = 2 * MAX_POINTS + 2;
  localparam int unsigned SIW  = $clog2(SD);
  localparam int unsigned DW   = $clog2(SD + 1);

  typedef enum logic [4:0] {
    LOAD, SORT_NEXT, SORT_CUR, SORT_CHK, SORT_RJ, SORT_CMP, SORT_PUT,
    CH_NEXT, CH_P, CH_PD, CH_TEST, CH_RA, CH_RB, CH_RBD, CH_X, CH_PUSH,
    CLOSE, CL_F, CL_L, CL_LD, CAP, OUT_RD, OUT_P, OUT_PD, OUT_W
  } state_e;

  state_e state_q;
  logic [CNTW-1:0] cnt_q, i_q, j_q;
  logic [DW-1:0]   depth_q, floor_q, k_q;
  logic            upper_q;
  logic [IW-1:0]   o_q, p_q;
  logic signed [CW-1:0] cx_q, cy_q, ax_q, ay_q;
  logic            end_q;

  // memory ports
  logic p_we, s_we, k_we;
  logic [IW-1:0]  p_waddr, p_raddr, s_waddr, s_raddr, s_wdata, k_wdata;
  logic [SIW-1:0] k_waddr, k_raddr;
  logic [PW-1:0]  p_wdata, p_rdata;
  logic [IW-1:0]  s_rdata, k_rdata;

  chp_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_points (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  chp_ram #(.DEPTH(MAX_POINTS), .WIDTH(IW)) u_order (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  chp_ram #(.DEPTH(SD), .WIDTH(IW)) u_stack (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  // field decode: coordinate is the low COORD_BITS of the field
  logic [XW-1:0] in_x_ext, in_y_ext;
  logic signed [CW-1:0] in_x, in_y, rd_x, rd_y;
  logic [FIELD_W-1:0] rd_id;
  logic signed [XW-1:0] out_x_ext, out_y_ext;
  assign in_x_ext = XW'(s_axis_tdata_i[FIELD_W-1:0]);
  assign in_y_ext = XW'(s_axis_tdata_i[2*FIELD_W-1:FIELD_W]);
  assign in_x     = in_x_ext[CW-1:0];
  assign in_y     = in_y_ext[CW-1:0];
  assign rd_x     = p_rdata[CW-1:0];
  assign rd_y     = p_rdata[2*CW-1:CW];
  assign rd_id    = p_rdata[PW-1:2*CW];
  assign out_x_ext = XW'(rd_x);
  assign out_y_ext = XW'(rd_y);

  logic s_acc, m_acc, cur_less, same_pos;
  assign s_axis_tready_o = (state_q == LOAD);
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc    = m_axis_tvalid_o && m_axis_tready_i;
  assign cur_less = (cx_q < rd_x) || ((cx_q == rd_x) && (cy_q < rd_y));
  assign same_pos = (rd_x == ax_q) && (rd_y == ay_q);

  logic x_done, x_not_left;
  chp_cross #(.CW(CW)) u_cross (
    .clk_i, .rst_ni, .start_i(state_q == CH_RBD),
    .ax_i(ax_q), .ay_i(ay_q), .bx_i(rd_x), .by_i(rd_y),
    .px_i(cx_q), .py_i(cy_q), .done_o(x_done), .not_left_o(x_not_left)
  );

  // address and write steering
  always_comb begin
    p_we    = 1'b0;
    p_waddr = cnt_q[IW-1:0];
    p_wdata = {s_axis_tdata_i[3*FIELD_W-1:2*FIELD_W], in_y, in_x};
    p_raddr = k_rdata;
    s_we    = 1'b0;
    s_waddr = j_q[IW-1:0];
    s_wdata = o_q;
    s_raddr = IW'(j_q - CNTW'(1));
    k_we    = 1'b0;
    k_waddr = depth_q[SIW-1:0];
    k_wdata = p_q;
    k_raddr = SIW'(depth_q - DW'(1));
    unique case (state_q)
      LOAD:      p_we = s_acc && (cnt_q < CNTW'(MAX_POINTS));
      SORT_NEXT: p_raddr = i_q[IW-1:0];
      SORT_RJ:   p_raddr = s_rdata;
      SORT_CMP:  s_we = cur_less;
      SORT_PUT: begin
        s_we    = 1'b1;
        s_wdata = i_q[IW-1:0];
      end
      CH_NEXT:   s_raddr = upper_q ? IW'(i_q - CNTW'(2)) : i_q[IW-1:0];
      CH_P:      p_raddr = s_rdata;
      CH_TEST:   k_raddr = SIW'(depth_q - DW'(2));
      CH_PUSH:   k_we = (depth_q < DW'(SD));
      CLOSE:     k_raddr = '0;
      OUT_RD:    k_raddr = k_q[SIW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= LOAD;
      cnt_q           <= '0;
      i_q             <= '0;
      j_q             <= '0;
      depth_q         <= '0;
      floor_q         <= '0;
      k_q             <= '0;
      upper_q         <= 1'b0;
      m_axis_tvalid_o <= 1'b0;
      end_q           <= 1'b0;
    end else begin
      unique case (state_q)
        LOAD: if (s_acc) begin
          if (cnt_q < CNTW'(MAX_POINTS)) cnt_q <= cnt_q + CNTW'(1);
          if (s_axis_tlast_i) begin
            i_q     <= '0;
            state_q <= SORT_NEXT;
          end
        end
        // insertion sort, stable: shift only while strictly less
        SORT_NEXT: begin
          j_q <= i_q;
          if (i_q == cnt_q) begin
            depth_q <= '0;
            floor_q <= DW'(2);
            upper_q <= 1'b0;
            i_q     <= '0;
            state_q <= CH_NEXT;
          end else begin
            state_q <= SORT_CUR;
          end
        end
        SORT_CUR: begin
          cx_q    <= rd_x;
          cy_q    <= rd_y;
          state_q <= SORT_CHK;
        end
        SORT_CHK: state_q <= (j_q == '0) ? SORT_PUT : SORT_RJ;
        SORT_RJ: begin
          o_q     <= s_rdata;
          state_q <= SORT_CMP;
        end
        SORT_CMP: begin
          if (cur_less) begin
            j_q     <= j_q - CNTW'(1);
            state_q <= SORT_CHK;
          end else begin
            state_q <= SORT_PUT;
          end
        end
        SORT_PUT: begin
          i_q     <= i_q + CNTW'(1);
          state_q <= SORT_NEXT;
        end
        // monotone chain: lower pass, then upper pass
        CH_NEXT: begin
          if (!upper_q && (i_q == cnt_q)) begin
            upper_q <= 1'b1;
            floor_q <= depth_q + DW'(1);
            i_q     <= cnt_q;
          end else if (upper_q && (i_q < CNTW'(2))) begin
            state_q <= CLOSE;
          end else begin
            state_q <= CH_P;
          end
        end
        CH_P: begin
          p_q     <= s_rdata;
          state_q <= CH_PD;
        end
        CH_PD: begin
          cx_q    <= rd_x;
          cy_q    <= rd_y;
          state_q <= CH_TEST;
        end
        CH_TEST: state_q <= (depth_q >= floor_q && depth_q >= DW'(2)) ? CH_RA : CH_PUSH;
        CH_RA:   state_q <= CH_RB;
        CH_RB: begin
          ax_q    <= rd_x;
          ay_q    <= rd_y;
          state_q <= CH_RBD;
        end
        CH_RBD: state_q <= CH_X;
        CH_X: if (x_done) begin
          if (x_not_left) begin
            depth_q <= depth_q - DW'(1);
            state_q <= CH_TEST;
          end else begin
            state_q <= CH_PUSH;
          end
        end
        CH_PUSH: begin
          if (depth_q < DW'(SD)) depth_q <= depth_q + DW'(1);
          i_q     <= upper_q ? i_q - CNTW'(1) : i_q + CNTW'(1);
          state_q <= CH_NEXT;
        end
        // drop a closing copy of the first vertex
        CLOSE: state_q <= (depth_q > DW'(1)) ? CL_F : CAP;
        CL_F:  state_q <= CL_L;
        CL_L: begin
          ax_q    <= rd_x;
          ay_q    <= rd_y;
          state_q <= CL_LD;
        end
        CL_LD: begin
          if (same_pos) depth_q <= depth_q - DW'(1);
          state_q <= CAP;
        end
        CAP: begin
          if (depth_q > DW'(MAX_POINTS)) depth_q <= DW'(MAX_POINTS);
          k_q     <= '0;
          state_q <= OUT_RD;
        end
        OUT_RD: state_q <= OUT_P;
        OUT_P:  state_q <= OUT_PD;
        OUT_PD: begin
          m_axis_tdata_o  <= {rd_id, out_y_ext[FIELD_W-1:0], out_x_ext[FIELD_W-1:0]};
          end_q           <= (k_q + DW'(1) == depth_q);
          m_axis_tvalid_o <= 1'b1;
          state_q         <= OUT_W;
        end
        OUT_W: if (m_acc) begin
          m_axis_tvalid_o <= 1'b0;
          k_q             <= k_q + DW'(1);
          if (end_q) begin
            cnt_q   <= '0;
            depth_q <= '0;
            state_q <= LOAD;
          end else begin
            state_q <= OUT_RD;
          end
        end
        default: state_q <= LOAD;
      endcase
    end
  end

  assign m_axis_tlast_o = end_q;
endmodule

>>> rtl/core/chp_checker.sv
`timescale 1ns / 1ps
module chp_checker
  import chp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               s_axis_tlast_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tlast_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled vertex changed");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("accepting points while emitting hull");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("final point did not start computation");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("hull did not end after last vertex");
endmodule

bind convex_hull_2d_top chp_checker u_chp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tlast_i(s_axis_tlast_i), .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i), .m_axis_tdata_o(m_axis_tdata_o),
  .m_axis_tlast_o(m_axis_tlast_o)
);
